@@ rtl/sw_med_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding-window median package
// Shared constants and the control struct between the top level and the
// sorted-window cells.
// ----------------------------------------------------------------------------
package sw_med_pkg;

    localparam int CFG_WIDTH  = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic load;        // a request is accepted this cycle
        logic occupied;    // the cell holds a window sample
        logic evict_en;    // the window is full, so the oldest sample leaves
        logic first;       // the cell is the head of the row
        logic kept_here;   // the compacted window has an entry at this place
        logic ebi_here;    // an eviction at or below this cell
        logic ebi_prev;    // an eviction at or below the previous cell
    } t_cell_ctl;

endpackage

@@ rtl/sw_med_prefix.sv @@
// ----------------------------------------------------------------------------
// Sliding-window median prefix scan
// Inclusive OR scan over the eviction flags of the cell row, built as a
// logarithmic-depth parallel prefix network.
// ----------------------------------------------------------------------------
module sw_med_prefix #(
    parameter int N = 64
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_scan
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] w_lvl [0:LEVELS];

    assign w_lvl[0] = i_bits;

    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
        for (genvar j = 0; j < N; j++) begin : g_bit
            if (j >= (1 << k)) begin : g_or
                assign w_lvl[k+1][j] = w_lvl[k][j] | w_lvl[k][j-(1 << k)];
            end else begin : g_pass
                assign w_lvl[k+1][j] = w_lvl[k][j];
            end
        end
    end

    assign o_scan = w_lvl[LEVELS];

endmodule

@@ rtl/sw_med_cell.sv @@
// ----------------------------------------------------------------------------
// Sliding-window median cell
// One place of the sorted window: holds a sample and its age, and on each
// request takes its own, its neighbour's or the new sample so that the row
// stays sorted after the oldest sample leaves and the new one enters.
// ----------------------------------------------------------------------------
module sw_med_cell
    import sw_med_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 31,
    parameter int AGE_WIDTH    = 6
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [AGE_WIDTH-1:0]    i_oldest_age,
    input  logic [SAMPLE_WIDTH-1:0] i_prev_value,
    input  logic [AGE_WIDTH-1:0]    i_prev_age,
    input  logic                    i_prev_le,
    input  logic [SAMPLE_WIDTH-1:0] i_next_value,
    input  logic [AGE_WIDTH-1:0]    i_next_age,
    input  logic                    i_next_le,
    output logic [SAMPLE_WIDTH-1:0] o_value,
    output logic [AGE_WIDTH-1:0]    o_age,
    output logic                    o_le,
    output logic                    o_evict
);

    logic [SAMPLE_WIDTH-1:0] r_value;
    logic [AGE_WIDTH-1:0]    r_age;
    logic [SAMPLE_WIDTH-1:0] n_value;
    logic [AGE_WIDTH-1:0]    n_age;

    logic [SAMPLE_WIDTH-1:0] w_here_value;
    logic [AGE_WIDTH-1:0]    w_here_age;
    logic                    w_here_le;
    logic [SAMPLE_WIDTH-1:0] w_prev_value;
    logic [AGE_WIDTH-1:0]    w_prev_age;
    logic                    w_prev_le;

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_le    = (r_value <= i_sample);
    assign o_evict = i_ctl.occupied & i_ctl.evict_en & (r_age == i_oldest_age);

    // Entries of the window once the evicted sample has been taken out.
    always_comb begin
        w_here_value = i_ctl.ebi_here ? i_next_value : r_value;
        w_here_age   = i_ctl.ebi_here ? i_next_age   : r_age;
        w_here_le    = i_ctl.ebi_here ? i_next_le    : o_le;
        w_prev_value = i_ctl.ebi_prev ? r_value      : i_prev_value;
        w_prev_age   = i_ctl.ebi_prev ? r_age        : i_prev_age;
        w_prev_le    = i_ctl.ebi_prev ? o_le         : i_prev_le;

        if (i_ctl.kept_here && w_here_le) begin
            n_value = w_here_value;
            n_age   = w_here_age + AGE_WIDTH'(1);
        end else if (i_ctl.first || w_prev_le) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = w_prev_value;
            n_age   = w_prev_age + AGE_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

@@ rtl/sliding_window_median_top.sv @@
// ----------------------------------------------------------------------------
// Sliding-window median filter
// Streaming lower-median filter over the most recent samples, kept as a
// sorted row of cells with age tags that all update at once.
// ----------------------------------------------------------------------------
// Output: a sample that fills the window sets r_pend, and its median then
// moves from the cell row into the output register once that is free.
// Throughput: one sample per cycle while o_stall is low; the whole cell row updates at once.
// A finished window waits in the cell row while the output register is held,
// and only then is the input stalled, combinationally from the output stall.
// Reset (synchronous, active low) empties the window and sets the window
// size to three; the cell contents are left as they are.
// ----------------------------------------------------------------------------
module sliding_window_median_top
    import sw_med_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SAMPLE_WIDTH-1:0] o_median,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int EW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = (EW > CFG_WIDTH) ? EW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]    r_window_size;
    logic [EW-1:0]           r_fill;
    logic                    r_pend;
    logic [AW-1:0]           r_pidx;
    logic                    r_oval;
    logic [SAMPLE_WIDTH-1:0] r_median;

    logic [CW-1:0]           w_ws_ext;
    logic [EW-1:0]           w_win;
    logic                    w_evict;
    logic [EW-1:0]           w_rlen;
    logic [EW-1:0]           w_newfill;
    logic [AW-1:0]           w_oldest_age;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_cfg_wr;

    logic [SAMPLE_WIDTH-1:0] c_value [MAX_WINDOW];
    logic [AW-1:0]           c_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   c_le;
    logic [MAX_WINDOW-1:0]   c_evict;
    logic [MAX_WINDOW-1:0]   c_ebi;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == REG_WINDOW_SIZE) ?
                      APB_DATA_W'(r_window_size) : '0;

    always_comb begin
        w_ws_ext = CW'(r_window_size);
        if (w_ws_ext == '0) begin
            w_win = EW'(1);
        end else if (w_ws_ext > CW'(MAX_WINDOW)) begin
            w_win = EW'(MAX_WINDOW);
        end else begin
            w_win = EW'(w_ws_ext);
        end
    end

    assign w_evict      = (r_fill == w_win);
    assign w_rlen       = r_fill - EW'(w_evict);
    assign w_newfill    = w_rlen + EW'(1);
    assign w_oldest_age = AW'(w_win - EW'(1));

    assign w_out_free = ~r_oval | ~i_stall;
    assign o_stall    = r_pend & ~w_out_free;
    assign w_accept   = i_valid & ~o_stall;
    assign o_valid    = r_oval;
    assign o_median   = r_median;

    sw_med_prefix #(
        .N (MAX_WINDOW)
    ) u_prefix (
        .i_bits (c_evict),
        .o_scan (c_ebi)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        t_cell_ctl               w_ctl;
        logic [SAMPLE_WIDTH-1:0] w_prev_value;
        logic [AW-1:0]           w_prev_age;
        logic                    w_prev_le;
        logic [SAMPLE_WIDTH-1:0] w_next_value;
        logic [AW-1:0]           w_next_age;
        logic                    w_next_le;

        if (i == 0) begin : g_head
            assign w_prev_value = '0;
            assign w_prev_age   = '0;
            assign w_prev_le    = 1'b0;
            assign w_ctl.ebi_prev = 1'b0;
        end else begin : g_body
            assign w_prev_value = c_value[i-1];
            assign w_prev_age   = c_age[i-1];
            assign w_prev_le    = c_le[i-1];
            assign w_ctl.ebi_prev = c_ebi[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_tail
            assign w_next_value = '0;
            assign w_next_age   = '0;
            assign w_next_le    = 1'b0;
        end else begin : g_inner
            assign w_next_value = c_value[i+1];
            assign w_next_age   = c_age[i+1];
            assign w_next_le    = c_le[i+1];
        end

        assign w_ctl.load      = w_accept;
        assign w_ctl.occupied  = (EW'(i) < r_fill);
        assign w_ctl.evict_en  = w_evict;
        assign w_ctl.first     = (i == 0);
        assign w_ctl.kept_here = (EW'(i) < w_rlen);
        assign w_ctl.ebi_here  = c_ebi[i];

        sw_med_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_sample     (i_sample),
            .i_oldest_age (w_oldest_age),
            .i_prev_value (w_prev_value),
            .i_prev_age   (w_prev_age),
            .i_prev_le    (w_prev_le),
            .i_next_value (w_next_value),
            .i_next_age   (w_next_age),
            .i_next_le    (w_next_le),
            .o_value      (c_value[i]),
            .o_age        (c_age[i]),
            .o_le         (c_le[i]),
            .o_evict      (c_evict[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
            r_fill        <= '0;
            r_pend        <= 1'b0;
            r_oval        <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_WINDOW_SIZE) begin
                r_window_size <= pwdata[CFG_WIDTH-1:0];
                r_fill        <= '0;
            end else if (w_accept) begin
                r_fill <= w_newfill;
            end

            if (w_accept) begin
                r_pend <= (w_newfill == w_win);
            end else if (w_out_free) begin
                r_pend <= 1'b0;
            end

            if (w_out_free) begin
                r_oval <= r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pidx <= AW'((w_win - EW'(1)) >> 1);
        end
        if (w_out_free && r_pend) begin
            r_median <= c_value[r_pidx];
        end
    end

endmodule

@@ rtl/sw_med_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding-window median port checker
// Concurrent assertions on the ports of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module sw_med_checker
    import sw_med_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 31
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [SAMPLE_WIDTH-1:0] o_median,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [APB_ADDR_W-1:0]   paddr,
    input logic [APB_DATA_W-1:0]   pwdata,
    input logic [APB_DATA_W-1:0]   prdata,
    input logic                    pready
);

    // A result waiting on a stalled output keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_median))
        else $error("stalled result changed or was dropped");

    // Input back-pressure only ever comes from a blocked output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the output was free");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready deasserted");

    // A written window size reads back on the next cycle.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE
        ##1 paddr[2] == REG_WINDOW_SIZE
        |-> prdata[CFG_WIDTH-1:0] == $past(pwdata[CFG_WIDTH-1:0]))
        else $error("window size read-back mismatch");

endmodule

bind sliding_window_median_top sw_med_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sw_med_checker (.*);
